[rtl/motion_gesture_start_stop_detector_assert.svh]
// Assertion macros used by the gesture detector core.
`ifndef MOTION_GESTURE_START_STOP_DETECTOR_ASSERT_SVH
`define MOTION_GESTURE_START_STOP_DETECTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low.
`define MGSSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off while rst_n is low.
`define MGSSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mgssd_pkg.sv]
// Types and constants shared by the gesture detector modules.
package mgssd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int THR_W           = 16;
  localparam int CNT_W           = 6;
  localparam int CD_W            = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int PHASE_W         = 3;
  localparam int OUT_TDATA_W     = ((PHASE_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W     = 2;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0] STEADY_THR_RST   = THR_W'(150);
  localparam logic [THR_W-1:0] JERK_THR_RST     = THR_W'(300);
  localparam logic [CNT_W-1:0] CALIB_LIMIT_RST  = CNT_W'(40);
  localparam logic [CNT_W-1:0] ARM_MIN_RST      = CNT_W'(30);
  localparam logic [CNT_W-1:0] ARM_MAX_RST      = CNT_W'(56);
  localparam logic [CNT_W-1:0] REARM_AT_RST     = CNT_W'(55);
  localparam logic [CNT_W-1:0] REARM_VALUE_RST  = CNT_W'(30);
  localparam logic [CD_W-1:0]  COOLDOWN_LEN_RST = CD_W'(75);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEADY_THR   = 3'd0,
    CFG_JERK_THR     = 3'd1,
    CFG_CALIB_LIMIT  = 3'd2,
    CFG_ARM_MIN      = 3'd3,
    CFG_ARM_MAX      = 3'd4,
    CFG_REARM_AT     = 3'd5,
    CFG_REARM_VALUE  = 3'd6,
    CFG_COOLDOWN_LEN = 3'd7
  } cfg_idx_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_COOLDOWN  = 3'd0,
    PH_PRIMED    = 3'd1,
    PH_NOT_READY = 3'd2,
    PH_READY     = 3'd3,
    PH_RUNNING   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [THR_W-1:0] steady_thr;
    logic [THR_W-1:0] jerk_thr;
    logic [CNT_W-1:0] calib_limit;
    logic [CNT_W-1:0] arm_min;
    logic [CNT_W-1:0] arm_max;
    logic [CNT_W-1:0] rearm_at;
    logic [CNT_W-1:0] rearm_value;
    logic [CD_W-1:0]  cooldown_len;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic             short_pulse;
    logic             long_pulse;
    logic [CNT_W-1:0] steady_count;
  } result_t;

endpackage

[rtl/mgssd_cfg_regs.sv]
// Configuration register bank of the gesture detector.
module mgssd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mgssd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mgssd_pkg::CFG_DATA_W-1:0] cfg_data,
  output mgssd_pkg::cfg_t                  cfg
);
  import mgssd_pkg::*;

  cfg_t cfg_r;

  // Always able to take a write transaction
  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Load the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steady_thr   <= STEADY_THR_RST;
      cfg_r.jerk_thr     <= JERK_THR_RST;
      cfg_r.calib_limit  <= CALIB_LIMIT_RST;
      cfg_r.arm_min      <= ARM_MIN_RST;
      cfg_r.arm_max      <= ARM_MAX_RST;
      cfg_r.rearm_at     <= REARM_AT_RST;
      cfg_r.rearm_value  <= REARM_VALUE_RST;
      cfg_r.cooldown_len <= COOLDOWN_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEADY_THR:   cfg_r.steady_thr   <= cfg_data[THR_W-1:0];
        CFG_JERK_THR:     cfg_r.jerk_thr     <= cfg_data[THR_W-1:0];
        CFG_CALIB_LIMIT:  cfg_r.calib_limit  <= cfg_data[CNT_W-1:0];
        CFG_ARM_MIN:      cfg_r.arm_min      <= cfg_data[CNT_W-1:0];
        CFG_ARM_MAX:      cfg_r.arm_max      <= cfg_data[CNT_W-1:0];
        CFG_REARM_AT:     cfg_r.rearm_at     <= cfg_data[CNT_W-1:0];
        CFG_REARM_VALUE:  cfg_r.rearm_value  <= cfg_data[CNT_W-1:0];
        CFG_COOLDOWN_LEN: cfg_r.cooldown_len <= cfg_data[CD_W-1:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

endmodule

[rtl/mgssd_core.sv]
// Gesture state and per-sample evaluation of the gesture detector.
module mgssd_core #(
  parameter int SAMPLE_BITS = mgssd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mgssd_pkg::cfg_t               cfg,
  input  logic                          fire,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  output mgssd_pkg::result_t            res
);
  import mgssd_pkg::*;

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int CMP_W  = (DIFF_W > THR_W) ? DIFF_W : THR_W;

  logic signed [SAMPLE_BITS-1:0] last_x_r, last_y_r, last_z_r;
  logic                          primed_r, primed_nxt;
  logic                          running_r, running_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CD_W-1:0]               cooldown_r, cooldown_nxt;
  logic                          store;

  logic [CMP_W-1:0] dx, dy, dz, st_thr, jt_thr;
  logic             steady, jerk_all, unsteady_clear, start, wrap, eval_run, stop;
  logic [CNT_W-1:0] count_inc;

  // Magnitude of the difference of two samples, zero-extended for compares
  function automatic logic [CMP_W-1:0] abs_diff(input logic signed [SAMPLE_BITS-1:0] a,
                                                input logic signed [SAMPLE_BITS-1:0] b);
    logic signed [DIFF_W-1:0] d;
    logic        [DIFF_W-1:0] m;
    d = DIFF_W'(a) - DIFF_W'(b);
    m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return CMP_W'(m);
  endfunction

  // Axis deltas and threshold tests
  always_comb begin
    dx       = abs_diff(last_x_r, accel_x);
    dy       = abs_diff(last_y_r, accel_y);
    dz       = abs_diff(last_z_r, accel_z);
    st_thr   = CMP_W'(cfg.steady_thr);
    jt_thr   = CMP_W'(cfg.jerk_thr);
    steady   = (dx < st_thr) && (dy < st_thr) && (dz < st_thr);
    jerk_all = (dx > jt_thr) && (dy > jt_thr) && (dz > jt_thr);
  end

  // Decide the next state and the result of this sample
  always_comb begin
    count_inc      = count_r + CNT_W'(1);
    unsteady_clear = (count_r < cfg.calib_limit) && !steady;
    start          = !running_r && !unsteady_clear &&
                     (count_inc >= cfg.arm_min) && (count_inc <= cfg.arm_max) &&
                     (dy > jt_thr);
    wrap           = !running_r && !unsteady_clear && !start &&
                     (count_inc >= cfg.rearm_at);
    eval_run       = running_r || start;
    stop           = eval_run && jerk_all;

    primed_nxt       = primed_r;
    running_nxt      = running_r;
    count_nxt        = count_r;
    cooldown_nxt     = cooldown_r;
    store            = 1'b0;
    res.phase        = PH_RUNNING;
    res.short_pulse  = 1'b0;
    res.long_pulse   = 1'b0;

    priority if (cooldown_r != '0) begin
      cooldown_nxt = cooldown_r - CD_W'(1);
      res.phase    = PH_COOLDOWN;
    end else if (!running_r && !primed_r) begin
      primed_nxt = 1'b1;
      store      = 1'b1;
      res.phase  = PH_PRIMED;
    end else begin
      store = !wrap;
      if (!running_r) begin
        priority if (unsteady_clear) begin
          count_nxt = '0;
          res.phase = PH_NOT_READY;
        end else if (start) begin
          count_nxt       = '0;
          cooldown_nxt    = cfg.cooldown_len;
          res.short_pulse = 1'b1;
        end else if (wrap) begin
          count_nxt = cfg.rearm_value;
          res.phase = PH_READY;
        end else begin
          count_nxt = count_inc;
          res.phase = PH_READY;
        end
      end
      if (eval_run) begin
        running_nxt    = !stop;
        res.long_pulse = stop;
        res.phase      = PH_RUNNING;
      end
    end
    res.steady_count = count_nxt;
  end

  // Advance gesture state on each evaluated sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r   <= 1'b0;
      running_r  <= 1'b0;
      count_r    <= '0;
      cooldown_r <= '0;
    end else if (fire) begin
      primed_r   <= primed_nxt;
      running_r  <= running_nxt;
      count_r    <= count_nxt;
      cooldown_r <= cooldown_nxt;
    end
  end

  // Hold the previous sample for delta computation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= '0;
      last_y_r <= '0;
      last_z_r <= '0;
    end else if (fire && store) begin
      last_x_r <= accel_x;
      last_y_r <= accel_y;
      last_z_r <= accel_z;
    end
  end

`include "motion_gesture_start_stop_detector_assert.svh"

  `MGSSD_ASSERT_NOW(a_pulse_phase, fire && res.short_pulse, res.phase == PH_RUNNING, "start pulse outside running phase")
  `MGSSD_ASSERT_NOW(a_cooldown_quiet, fire && (cooldown_r != '0), !res.short_pulse && !res.long_pulse && (res.phase == PH_COOLDOWN), "activity during cooldown")
  `MGSSD_ASSERT_NXT(a_start_loads_cd, fire && res.short_pulse, (cooldown_r == $past(cfg.cooldown_len)) && (count_r == '0), "start did not load cooldown")
  `MGSSD_ASSERT_NXT(a_stop_clears_run, fire && res.long_pulse, !running_r, "stop left block running")

endmodule

[rtl/motion_gesture_start_stop_detector.sv]
// Top level of the motion gesture start/stop detector.
// An accepted sample is held in the input register, then its result is registered on out_.
// Throughput: one sample per cycle while out_tready allows; input register, then delta compares
// and state update into the output register, with backpressure passed straight through both stages.
// Reset: synchronous active-low rst_n empties both stages, clears gesture state and
// restores the configuration registers to their defaults.
module motion_gesture_start_stop_detector #(
  parameter int SAMPLE_BITS = mgssd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [SB-1:0] accel_x, [2SB-1:SB] accel_y, [3SB-1:2SB] accel_z, zero pad to bytes
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] phase, [8:3] steady_count, zero pad to bytes
  output logic [mgssd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] short_pulse, [1] long_pulse
  output logic [mgssd_pkg::OUT_TUSER_W-1:0] out_tuser,
  // Configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mgssd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mgssd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mgssd_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - PHASE_W - CNT_W;

  cfg_t    cfg;
  result_t res;

  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic                          out_valid_r;
  result_t                       out_res_r;
  logic                          out_free, fire;

  // Advance when the output register is empty or being drained
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  mgssd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mgssd_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (fire),
    .accel_x (s1_x_r),
    .accel_y (s1_y_r),
    .accel_z (s1_z_r),
    .res     (res)
  );

  // Input register: capture each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_x_r <= in_tdata[SAMPLE_BITS-1:0];
      s1_y_r <= in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      s1_z_r <= in_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    end
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {PAD_W'(0), out_res_r.steady_count, out_res_r.phase};
  assign out_tuser  = {out_res_r.long_pulse, out_res_r.short_pulse};

endmodule
